### design/tcce_pkg.sv
package tcce_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Field widths.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_COLOR, CH_BLANK};

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic exec;
        logic start_copy;
        logic start_clear;
        logic copy;
        logic flush;
        logic blank;
        logic fill_init;
        logic fill_clear;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic scroll_need;
        logic sweep_last;
        logic out_free;
    } t_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage

### design/tcce_in_if.sv
interface tcce_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [tcce_pkg::CHAR_W-1:0] char_code;
    logic [tcce_pkg::CHAR_W-1:0] cell_color;
    logic [tcce_pkg::COL_W-1:0]  cell_column;
    logic [tcce_pkg::ROW_W-1:0]  cell_row;

    modport source (output valid, output op, output char_code, output cell_color,
                    output cell_column, output cell_row, input ready);
    modport sink   (input valid, input op, input char_code, input cell_color,
                    input cell_column, input cell_row, output ready);
endinterface

### design/tcce_out_if.sv
interface tcce_out_if;
    logic                        valid;
    logic                        ready;
    logic [tcce_pkg::CELL_W-1:0] cell_value;
    logic [tcce_pkg::COL_W-1:0]  cursor_column;
    logic [tcce_pkg::ROW_W-1:0]  cursor_row;
    logic                        bad_position;

    modport source (output valid, output cell_value, output cursor_column,
                    output cursor_row, output bad_position, input ready);
    modport sink   (input valid, input cell_value, input cursor_column,
                    input cursor_row, input bad_position, output ready);
endinterface

### design/tcce_cfg_if.sv
interface tcce_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tcce_pkg::CHAR_W-1:0] text_color;

    modport source (output valid, output text_color, input ready);
    modport sink   (input valid, input text_color, output ready);
endinterface

### design/tcce_ctrl.sv
module tcce_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tcce_pkg::t_stat i_stat,
    output tcce_pkg::t_cmd  o_cmd
);
    import tcce_pkg::*;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_COPY  = 8'b0000_1000,
        S_FLUSH = 8'b0001_0000,
        S_BLANK = 8'b0010_0000,
        S_CLEAR = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill_init = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.op == OP_CLEAR) begin
                    o_cmd.start_clear = 1'b1;
                    n_state           = S_CLEAR;
                end else if (i_stat.scroll_need) begin
                    o_cmd.start_copy = 1'b1;
                    n_state          = S_COPY;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_BLANK;
            end
            S_BLANK: begin
                o_cmd.blank = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.fill_clear = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/tcce_datapath.sv
module tcce_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcce_pkg::t_cmd                i_cmd,
    output tcce_pkg::t_stat               o_stat,
    input  logic [1:0]                    i_op,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_cell_color,
    input  logic [tcce_pkg::COL_W-1:0]    i_cell_column,
    input  logic [tcce_pkg::ROW_W-1:0]    i_cell_row,
    input  logic                          i_cfg_valid,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_cfg_text_color,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tcce_pkg::CELL_W-1:0]   o_cell_value,
    output logic [tcce_pkg::COL_W-1:0]    o_cursor_column,
    output logic [tcce_pkg::ROW_W-1:0]    o_cursor_row,
    output logic                          o_bad_position
);
    import tcce_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW1_ADDR   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    logic [CELL_W-1:0] mem [CELLS];

    logic [CHAR_W-1:0] r_color;
    logic [ROW_W-1:0]  r_cur_row;
    logic [COL_W-1:0]  r_cur_col;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_wa;
    logic              r_pend;

    t_op               r_op;
    logic [CHAR_W-1:0] r_char;
    logic [CHAR_W-1:0] r_attr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    logic [CELL_W-1:0] r_rdata;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_cell_value;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic              r_bad;

    logic              in_screen;
    logic              is_bs;
    logic              is_nl;
    logic              last_row;
    logic              last_col;
    logic [ROW_W-1:0]  bs_row;
    logic [COL_W-1:0]  bs_col;
    logic [ROW_W-1:0]  n_cur_row;
    logic [COL_W-1:0]  n_cur_col;
    logic [ADDR_W-1:0] put_addr;
    logic [ADDR_W-1:0] pos_addr;
    logic [CELL_W-1:0] blank_cell;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [CELL_W-1:0] wd;
    logic              re;
    logic [ADDR_W-1:0] ra;

    assign in_screen = ({1'b0, r_col} < (COL_W + 1)'(COLUMNS))
                    && ({1'b0, r_row} < (ROW_W + 1)'(ROWS));
    assign is_bs    = (r_char == CH_BACKSPACE);
    assign is_nl    = (r_char == CH_NEWLINE);
    assign last_row = (r_cur_row == LAST_ROW);
    assign last_col = (r_cur_col == LAST_COL);
    assign blank_cell = {r_color, CH_BLANK};
    assign pos_addr   = cell_addr(r_row, r_col);

    // Backspace target: back one column, wrapping to the previous row, held at the origin.
    always_comb begin
        bs_row = r_cur_row;
        bs_col = r_cur_col;
        if (r_cur_col != '0) begin
            bs_col = r_cur_col - COL_W'(1);
        end else if (r_cur_row != '0) begin
            bs_row = r_cur_row - ROW_W'(1);
            bs_col = LAST_COL;
        end
    end

    assign put_addr = is_bs ? cell_addr(bs_row, bs_col) : cell_addr(r_cur_row, r_cur_col);

    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        if (is_bs) begin
            n_cur_row = bs_row;
            n_cur_col = bs_col;
        end else if (is_nl || last_col) begin
            n_cur_col = '0;
            if (!last_row) begin
                n_cur_row = r_cur_row + ROW_W'(1);
            end
        end else begin
            n_cur_col = r_cur_col + COL_W'(1);
        end
    end

    assign o_stat.op          = r_op;
    assign o_stat.scroll_need = (r_op == OP_PUT) && last_row
                             && (is_nl || (!is_bs && last_col));
    assign o_stat.sweep_last  = (r_addr == LAST_ADDR);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // Write port selection.
    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = blank_cell;
        if (i_cmd.fill_init) begin
            we = 1'b1;
            wd = RESET_CELL;
        end else if (i_cmd.fill_clear || i_cmd.blank) begin
            we = 1'b1;
        end else if (i_cmd.copy || i_cmd.flush) begin
            we = i_cmd.flush || r_pend;
            wa = r_wa;
            wd = r_rdata;
        end else if (i_cmd.exec) begin
            if (r_op == OP_PUT && !is_nl) begin
                we = 1'b1;
                wa = put_addr;
                wd = is_bs ? blank_cell : {r_color, r_char};
            end else if (r_op == OP_WRITE && in_screen) begin
                we = 1'b1;
                wa = pos_addr;
                wd = {r_attr, r_char};
            end
        end
    end

    assign re = i_cmd.copy || (i_cmd.exec && r_op == OP_READ && in_screen);
    assign ra = i_cmd.copy ? r_addr : pos_addr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rdata <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= RESET_COLOR;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_op        <= OP_PUT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_color <= i_cfg_text_color;
            end
            if (i_cmd.take) begin
                r_op <= t_op'(i_op);
            end
            if (i_cmd.exec) begin
                if (r_op == OP_PUT) begin
                    r_cur_row <= n_cur_row;
                    r_cur_col <= n_cur_col;
                end else if (r_op == OP_CLEAR) begin
                    r_cur_row <= '0;
                    r_cur_col <= '0;
                end
            end
            // Sweep address: copy reads from row one onward, writing each cell one row up in the following cycle.
            if (i_cmd.start_copy) begin
                r_addr <= ROW1_ADDR;
                r_pend <= 1'b0;
            end else if (i_cmd.start_clear) begin
                r_addr <= '0;
            end else if (i_cmd.flush) begin
                r_addr <= BOTTOM_ADDR;
                r_pend <= 1'b0;
            end else if (i_cmd.copy) begin
                r_addr <= r_addr + ADDR_W'(1);
                r_pend <= 1'b1;
            end else if (i_cmd.fill_init || i_cmd.fill_clear || i_cmd.blank) begin
                if (r_addr != LAST_ADDR) begin
                    r_addr <= r_addr + ADDR_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_char <= i_char_code;
            r_attr <= i_cell_color;
            r_col  <= i_cell_column;
            r_row  <= i_cell_row;
        end
        if (i_cmd.copy) begin
            r_wa <= r_addr - ROW1_ADDR;
        end
        if (i_cmd.load_out) begin
            r_cell_value <= (r_op == OP_READ && in_screen) ? r_rdata : '0;
            r_bad        <= (r_op == OP_WRITE || r_op == OP_READ) && !in_screen;
            r_out_col    <= r_cur_col;
            r_out_row    <= r_cur_row;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_value    = r_cell_value;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_bad_position  = r_bad;

endmodule

### design/text_console_cursor_engine.sv
// Text console: a ROWS x COLUMNS screen of 16-bit cells (attribute high byte,
// glyph low byte) and a cursor, driven one transaction at a time.
// i_in carries one operation per transaction: put character, write cell, read
// cell or clear screen. o_out returns one result per operation: the cell read
// (zero otherwise), the cursor after the operation and a bad position flag.
// i_cfg writes the attribute used for printed characters, blanks and clears;
// it is always ready and should be written only while the console is idle.
// A scroll walks the screen store through its single read and write port;
// a clear writes every cell once. After reset the store is swept to blanks
// in attribute 0x07 before the first input transaction is accepted.
// The result sits in an output register; if the receiver stalls, a finished
// operation waits for that register and no new input is taken meanwhile.
module text_console_cursor_engine (
    input logic    i_clk,
    input logic    i_rst_n,
    tcce_in_if.sink    i_in,
    tcce_out_if.source o_out,
    tcce_cfg_if.sink   i_cfg
);
    import tcce_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    tcce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcce_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (i_in.op),
        .i_char_code      (i_in.char_code),
        .i_cell_color     (i_in.cell_color),
        .i_cell_column    (i_in.cell_column),
        .i_cell_row       (i_in.cell_row),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_text_color (i_cfg.text_color),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_cell_value     (o_out.cell_value),
        .o_cursor_column  (o_out.cursor_column),
        .o_cursor_row     (o_out.cursor_row),
        .o_bad_position   (o_out.bad_position)
    );

endmodule

### bench/tcce_screen_check.sv
module tcce_screen_check (
    input  logic i_clk,
    input  logic i_rst_n,
    tcce_in_if   in_ch,
    tcce_out_if  out_ch,
    tcce_cfg_if  cfg_ch,
    output int   o_failures,
    output int   o_pending
);
    import tcce_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              bad;
    } t_console_result;

    logic [CELL_W-1:0] screen [CELLS];
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic [CHAR_W-1:0] attr;
    t_console_result   expected_q [$];
    int                failures = 0;

    function automatic void blank_screen(input logic [CHAR_W-1:0] color);
        for (int i = 0; i < CELLS; i++) begin
            screen[i] = {color, CH_BLANK};
        end
    endfunction

    // Newline and wrap both land here; on the last row the screen scrolls up.
    function automatic void advance_row();
        cur_col = '0;
        if (int'(cur_row) + 1 >= ROWS) begin
            for (int i = COLUMNS; i < CELLS; i++) begin
                screen[i - COLUMNS] = screen[i];
            end
            for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                screen[i] = {attr, CH_BLANK};
            end
        end else begin
            cur_row = cur_row + 1'b1;
        end
    endfunction

    function automatic t_console_result apply_console_op(input t_op op,
                                                         input logic [CHAR_W-1:0] ch,
                                                         input logic [CHAR_W-1:0] color,
                                                         input logic [COL_W-1:0] col,
                                                         input logic [ROW_W-1:0] row);
        t_console_result res;
        logic            fits;
        int              addr;
        int              spot;
        res  = '0;
        fits = (int'(col) < COLUMNS) && (int'(row) < ROWS);
        addr = int'(row) * COLUMNS + int'(col);
        case (op)
            OP_PUT: begin
                if (ch == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col = cur_col - 1'b1;
                    end else if (cur_row > 0) begin
                        cur_row = cur_row - 1'b1;
                        cur_col = COL_W'(COLUMNS - 1);
                    end
                    spot = int'(cur_row) * COLUMNS + int'(cur_col);
                    screen[spot] = {attr, CH_BLANK};
                end else if (ch == CH_NEWLINE) begin
                    advance_row();
                end else begin
                    spot = int'(cur_row) * COLUMNS + int'(cur_col);
                    screen[spot] = {attr, ch};
                    if (int'(cur_col) + 1 >= COLUMNS) begin
                        advance_row();
                    end else begin
                        cur_col = cur_col + 1'b1;
                    end
                end
            end
            OP_WRITE: begin
                if (fits) begin
                    screen[addr] = {color, ch};
                end else begin
                    res.bad = 1'b1;
                end
            end
            OP_READ: begin
                if (fits) begin
                    res.value = screen[addr];
                end else begin
                    res.bad = 1'b1;
                end
            end
            default: begin
                blank_screen(attr);
                cur_row = '0;
                cur_col = '0;
            end
        endcase
        res.col = cur_col;
        res.row = cur_row;
        return res;
    endfunction

    function automatic void report(input string what, input t_console_result want,
                                   input t_console_result got);
        failures++;
        if (failures <= 10) begin
            $display("%s: expected cell %04h col %0d row %0d bad %0b,",
                     what, want.value, want.col, want.row, want.bad,
                     " got cell %04h col %0d row %0d bad %0b",
                     got.value, got.col, got.row, got.bad);
        end
    endfunction

    always @(posedge i_clk) begin
        t_console_result want;
        t_console_result got;
        if (!i_rst_n) begin
            blank_screen(RESET_COLOR);
            cur_row = '0;
            cur_col = '0;
            attr    = RESET_COLOR;
            expected_q.delete();
        end else begin
            // Results are retired before new operations are queued, so a result
            // can never be matched against the transaction taken on the same edge.
            if (out_ch.valid && out_ch.ready) begin
                got.value = out_ch.cell_value;
                got.col   = out_ch.cursor_column;
                got.row   = out_ch.cursor_row;
                got.bad   = out_ch.bad_position;
                if (expected_q.size() == 0) begin
                    report("result with nothing outstanding", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        report("result mismatch", want, got);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                attr = cfg_ch.text_color;
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_q.push_back(apply_console_op(t_op'(in_ch.op), in_ch.char_code,
                                                      in_ch.cell_color, in_ch.cell_column,
                                                      in_ch.cell_row));
            end
        end
        o_pending  = expected_q.size();
        o_failures = failures;
    end

endmodule

### bench/text_console_cursor_engine_test.sv
module text_console_cursor_engine_test;
    import tcce_pkg::*;

    // Worst case per item: a full scroll plus long gaps on both sides, for about
    // 1400 items, after the power-up sweep of the store, taken four times over.
    localparam int CYCLE_LIMIT = 4 * (CELLS + 1400 * (CELLS + 3 + 100));
    localparam int SETTLE      = 16;

    logic i_clk;
    logic i_rst_n;
    int   cycles = 0;
    int   items_sent = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   failures;
    int   pending;

    tcce_in_if  in_ch ();
    tcce_out_if out_ch ();
    tcce_cfg_if cfg_ch ();

    text_console_cursor_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tcce_screen_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_ch     (cfg_ch),
        .o_failures (failures),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_op(input t_op op, input logic [CHAR_W-1:0] ch,
                           input logic [CHAR_W-1:0] color, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.char_code   <= ch;
        in_ch.cell_color  <= color;
        in_ch.cell_column <= col;
        in_ch.cell_row    <= row;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    // The position fields are don't-care for a put, so they carry noise.
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_op(OP_PUT, ch, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
    endtask

    task automatic read_cell(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        send_op(OP_READ, CHAR_W'($urandom), CHAR_W'($urandom), col, row);
    endtask

    function automatic logic [CHAR_W-1:0] printable_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom); while (c == CH_BACKSPACE || c == CH_NEWLINE);
        return c;
    endfunction

    // Mostly on the screen; the rest falls off the right edge or the bottom.
    task automatic pick_position(output logic [COL_W-1:0] col, output logic [ROW_W-1:0] row);
        col = COL_W'($urandom_range(COLUMNS - 1));
        row = ROW_W'($urandom_range(ROWS - 1));
        if ($urandom_range(99) >= 85) begin
            if ($urandom_range(1)) begin
                col = COL_W'($urandom_range((1 << COL_W) - 1, COLUMNS));
                row = ROW_W'($urandom);
            end else begin
                row = ROW_W'($urandom_range((1 << ROW_W) - 1, ROWS));
            end
        end
    endtask

    task automatic wait_idle(input int settle);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_text_color(input logic [CHAR_W-1:0] color);
        wait_idle(SETTLE);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.text_color <= color;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(input int target);
        int               kind;
        int               n;
        logic [COL_W-1:0] cols [4];
        logic [ROW_W-1:0] rows [4];
        while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                // A line of text; the long ones wrap, and on the last row scroll.
                n = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(12, 1);
                repeat (n) put_char(printable_char());
                if ($urandom_range(1)) begin
                    put_char(CH_NEWLINE);
                end
            end else if (kind < 45) begin
                n = ($urandom_range(4) == 0) ? $urandom_range(30, 20) : $urandom_range(10, 1);
                repeat (n) put_char(CH_NEWLINE);
            end else if (kind < 55) begin
                n = ($urandom_range(6) == 0) ? $urandom_range(170, 70) : $urandom_range(6, 1);
                repeat (n) put_char(CH_BACKSPACE);
            end else if (kind < 70) begin
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) begin
                    pick_position(cols[i], rows[i]);
                    send_op(OP_WRITE, CHAR_W'($urandom), CHAR_W'($urandom), cols[i], rows[i]);
                end
                for (int i = 0; i < n; i++) begin
                    read_cell(cols[i], rows[i]);
                end
            end else if (kind < 85) begin
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) begin
                    pick_position(cols[0], rows[0]);
                    read_cell(cols[0], rows[0]);
                end
            end else if (kind < 97) begin
                n = $urandom_range(3, 1);
                repeat (n) begin
                    send_op(t_op'($urandom_range(3)), CHAR_W'($urandom), CHAR_W'($urandom),
                            COL_W'($urandom), ROW_W'($urandom));
                end
            end else begin
                send_op(OP_CLEAR, CHAR_W'($urandom), CHAR_W'($urandom),
                        COL_W'($urandom), ROW_W'($urandom));
            end
            if ($urandom_range(99) == 0) begin
                wait_idle(SETTLE);
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_PUT;
        in_ch.char_code   = '0;
        in_ch.cell_color  = '0;
        in_ch.cell_column = '0;
        in_ch.cell_row    = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.text_color = '0;
        out_ch.ready      = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: corners, both edges of the screen, and the cursor corner cases
        // under the reset attribute.
        read_cell('0, '0);
        read_cell(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        read_cell(COL_W'(COLUMNS), '0);
        read_cell('1, '1);
        send_op(OP_WRITE, 8'hFF, 8'hFF, '0, '0);
        send_op(OP_WRITE, 8'h00, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        send_op(OP_WRITE, 8'hAA, 8'h55, '0, ROW_W'(ROWS));
        send_op(OP_WRITE, 8'h55, 8'hAA, '1, '1);
        read_cell('0, '0);
        read_cell(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        put_char(CH_BACKSPACE);
        read_cell('0, '0);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_NEWLINE);
        put_char(CH_BACKSPACE);
        put_char(8'h41);
        read_cell(COL_W'(COLUMNS - 1), '0);
        read_cell(7'd1, '0);
        send_op(OP_CLEAR, 8'hFF, 8'hFF, '1, '1);
        read_cell(COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));

        // Phase with no idling: walk the cursor to the bottom, scroll by newline,
        // then fill the last row so that the wrap scrolls too.
        set_text_color(8'hFF);
        repeat (ROWS) put_char(CH_NEWLINE);
        repeat (COLUMNS) put_char(printable_char());
        put_char(CH_BACKSPACE);
        read_cell('0, ROW_W'(ROWS - 2));
        run_random(325);

        send_idle_pct = 68;
        set_text_color(8'h00);
        run_random(650);

        send_idle_pct  = 0;
        recv_stall_pct = 68;
        set_text_color(CHAR_W'($urandom));
        run_random(975);

        send_idle_pct  = 28;
        recv_stall_pct = 28;
        set_text_color(CHAR_W'($urandom));
        run_random(1300);

        wait_idle(SETTLE);
        if (failures == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
